@@ rtl/pai_pkg.sv @@
// Package for the pair agreement index block: sizes, request/response
// structs and the control state type. No dependencies.
package pai_pkg;

  // Set capacity and label width
  localparam int MaxItems  = 1024;
  localparam int LabelBits = 16;

  // Derived widths
  localparam int AddrW   = $clog2(MaxItems);
  localparam int CntW    = $clog2(MaxItems + 1);
  localparam int PairW   = 19;
  localparam int FracW   = 16;
  localparam int IndexW  = 17;
  localparam int DivW    = PairW + FracW;
  localparam int DivCntW = $clog2(DivW);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PAIRS,
    ST_DIV,
    ST_LOAD
  } pai_state_e;

  // Request into the scan unit
  typedef struct packed {
    logic                 start;
    logic [LabelBits-1:0] label_a;
    logic [LabelBits-1:0] label_b;
    logic [CntW-1:0]      count;
  } scan_req_t;

  // Status back from the scan unit
  typedef struct packed {
    logic hit;
    logic done;
  } scan_rsp_t;

endpackage

@@ rtl/pai_if.sv @@
// Handshake interfaces for the input and result channels.
// Depends on pai_pkg for field widths.
interface pai_in_if;
  logic                         valid;
  logic                         ready;
  logic [15:0]                  label_a;
  logic [15:0]                  label_b;
  logic                         last_item;

  modport source (output valid, label_a, label_b, last_item, input ready);
  modport sink   (input valid, label_a, label_b, last_item, output ready);
endinterface

interface pai_out_if;
  logic                         valid;
  logic                         ready;
  logic [pai_pkg::PairW-1:0]    agree_count;
  logic [pai_pkg::PairW-1:0]    pair_count;
  logic [pai_pkg::IndexW-1:0]   index_q16;
  logic                         valid_res;
  logic                         overflow;

  modport source (output valid, agree_count, pair_count, index_q16, valid_res, overflow,
                  input ready);
  modport sink   (input valid, agree_count, pair_count, index_q16, valid_res, overflow,
                  output ready);
endinterface

@@ rtl/pai_scan.sv @@
// Scan unit: label store plus one shared compare stage that walks all
// stored elements of the set, then writes the new element. Uses pai_pkg.
module pai_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pai_pkg::scan_req_t req_i,
  output pai_pkg::scan_rsp_t rsp_o
);

  // Both labels of one element per memory word
  logic [2*pai_pkg::LabelBits-1:0] mem_q [pai_pkg::MaxItems];
  logic [2*pai_pkg::LabelBits-1:0] rd_data_q;

  logic [pai_pkg::CntW-1:0]      idx_q, n_q;
  logic [pai_pkg::LabelBits-1:0] a_q, b_q;
  logic                          busy_q, pend_q;
  logic                          issue, fin;
  logic                          eq_a, eq_b;

  assign issue = busy_q && (idx_q < n_q);
  assign fin   = busy_q && !issue && !pend_q;

  // Walk control: one read issued per cycle, the registered read data compared in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      idx_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      pend_q <= 1'b0;
      idx_q  <= '0;
    end else if (busy_q) begin
      pend_q <= issue;
      if (issue) idx_q <= idx_q + pai_pkg::CntW'(1);
      if (fin)   busy_q <= 1'b0;
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.label_a;
      b_q <= req_i.label_b;
      n_q <= req_i.count;
    end
  end

  // Store: registered read, write of the new element after the walk
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[idx_q[pai_pkg::AddrW-1:0]];
    if (fin) mem_q[n_q[pai_pkg::AddrW-1:0]] <= {a_q, b_q};
  end

  // Agreement: equal in both labelings or different in both
  assign eq_a = rd_data_q[2*pai_pkg::LabelBits-1:pai_pkg::LabelBits] == a_q;
  assign eq_b = rd_data_q[pai_pkg::LabelBits-1:0] == b_q;

  assign rsp_o.hit  = pend_q && (eq_a == eq_b);
  assign rsp_o.done = fin;

endmodule

@@ rtl/pai_div.sv @@
// Restoring divider, one quotient bit per cycle: (agree << 16) / pairs.
// Uses pai_pkg for widths.
module pai_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pai_pkg::PairW-1:0]  agree_i,
  input  logic [pai_pkg::PairW-1:0]  pairs_i,
  output logic                       done_o,
  output logic [pai_pkg::IndexW-1:0] quot_o
);

  logic [pai_pkg::DivW-1:0]    dvd_q;
  logic [pai_pkg::PairW:0]     rem_q;
  logic [pai_pkg::PairW-1:0]   dsr_q;
  logic [pai_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [pai_pkg::PairW:0]     rem_sh, rem_sub;
  logic                        ge;

  // One shift/subtract step
  assign rem_sh  = {rem_q[pai_pkg::PairW-1:0], dvd_q[pai_pkg::DivW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + pai_pkg::DivCntW'(1);
        if (cnt_q == pai_pkg::DivCntW'(pai_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {agree_i, {pai_pkg::FracW{1'b0}}};
      rem_q <= '0;
      dsr_q <= pairs_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub : rem_sh;
      dvd_q <= {dvd_q[pai_pkg::DivW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q[pai_pkg::IndexW-1:0];

endmodule

@@ rtl/pair_agreement_index.sv @@
// Pair agreement (Rand) index over one set of elements.
// Depends on pai_pkg, pai_in_if/pai_out_if, pai_scan and pai_div.
//
// Usage: each request on in_i carries one element's two labels. The
// element is compared against every element already stored in the set,
// then stored. The request marked last_item closes the set: one result
// appears on out_o with the agreement count, the pair count n(n-1)/2,
// the ratio as unsigned Q1.16, a flag that n >= 2 and an overflow flag.
// Elements beyond 1024 per set are dropped and raise overflow.
//
// Timing: while an element is compared, in_i ready stays low; the
// element is walked against the stored set one entry per cycle through
// the single read port of the label store, and ready returns once the
// new element is written. A last element then passes through the pair
// count, the bit-serial divider (35 steps, skipped when n < 2) and the
// load of the result register.
// Reset clears counters and flags; the store needs no clearing pass.
// A stalled result waits in its output register while the next set's
// elements are taken; only the next result waits for it to drain.
module pair_agreement_index (
  input  logic     clk_i,
  input  logic     rst_ni,
  pai_in_if.sink   in_i,
  pai_out_if.source out_o
);

  pai_pkg::pai_state_e state_q, state_d;

  logic [pai_pkg::CntW-1:0]   count_q;
  logic [pai_pkg::PairW-1:0]  agree_q, pairs_q;
  logic                       dropped_q, last_q, nvalid_q;

  logic                       accept, room, scan_start, div_start, load;
  logic [pai_pkg::CntW-1:0]   cnt_m1;
  logic [2*pai_pkg::CntW-1:0] prod;

  pai_pkg::scan_req_t scan_req;
  pai_pkg::scan_rsp_t scan_rsp;
  logic                       div_done;
  logic [pai_pkg::IndexW-1:0] quot;

  // Output register
  logic                       out_valid_q;
  logic [pai_pkg::PairW-1:0]  out_agree_q, out_pairs_q;
  logic [pai_pkg::IndexW-1:0] out_index_q;
  logic                       out_vres_q, out_ovf_q;

  assign accept = in_i.valid && in_i.ready;
  assign room   = count_q < pai_pkg::CntW'(pai_pkg::MaxItems);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pai_pkg::ST_IDLE: begin
        if (accept) begin
          if (room)                state_d = pai_pkg::ST_SCAN;
          else if (in_i.last_item) state_d = pai_pkg::ST_PAIRS;
        end
      end
      pai_pkg::ST_SCAN: begin
        if (scan_rsp.done) state_d = last_q ? pai_pkg::ST_PAIRS : pai_pkg::ST_IDLE;
      end
      pai_pkg::ST_PAIRS: begin
        state_d = (count_q >= pai_pkg::CntW'(2)) ? pai_pkg::ST_DIV : pai_pkg::ST_LOAD;
      end
      pai_pkg::ST_DIV: begin
        if (div_done) state_d = pai_pkg::ST_LOAD;
      end
      pai_pkg::ST_LOAD: begin
        if (load) state_d = pai_pkg::ST_IDLE;
      end
      default: state_d = pai_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_i.ready = (state_q == pai_pkg::ST_IDLE);
    scan_start = accept && room;
    div_start  = (state_q == pai_pkg::ST_PAIRS) && (count_q >= pai_pkg::CntW'(2));
    load       = (state_q == pai_pkg::ST_LOAD) && (!out_valid_q || out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pai_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Scan unit
  assign scan_req.start   = scan_start;
  assign scan_req.label_a = in_i.label_a;
  assign scan_req.label_b = in_i.label_b;
  assign scan_req.count   = count_q;

  pai_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .rsp_o  (scan_rsp)
  );

  // Pair count n(n-1)/2
  assign cnt_m1 = count_q - pai_pkg::CntW'(1);
  assign prod   = count_q * cnt_m1;

  pai_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .agree_i (agree_q),
    .pairs_i (prod[pai_pkg::PairW:1]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Set state: counts and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      agree_q   <= '0;
      dropped_q <= 1'b0;
      last_q    <= 1'b0;
      pairs_q   <= '0;
      nvalid_q  <= 1'b0;
    end else begin
      if (accept) begin
        last_q <= in_i.last_item;
        if (!room) dropped_q <= 1'b1;
      end
      if (scan_rsp.hit)  agree_q <= agree_q + pai_pkg::PairW'(1);
      if (scan_rsp.done) count_q <= count_q + pai_pkg::CntW'(1);
      if (state_q == pai_pkg::ST_PAIRS) begin
        nvalid_q <= count_q >= pai_pkg::CntW'(2);
        pairs_q  <= (count_q >= pai_pkg::CntW'(2)) ? prod[pai_pkg::PairW:1] : '0;
      end
      if (load) begin
        count_q   <= '0;
        agree_q   <= '0;
        dropped_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (load) out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_agree_q <= agree_q;
      out_pairs_q <= pairs_q;
      out_index_q <= nvalid_q ? quot : '0;
      out_vres_q  <= nvalid_q;
      out_ovf_q   <= dropped_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.agree_count = out_agree_q;
  assign out_o.pair_count  = out_pairs_q;
  assign out_o.index_q16   = out_index_q;
  assign out_o.valid_res   = out_vres_q;
  assign out_o.overflow    = out_ovf_q;

endmodule

@@ rtl/pai_checker.sv @@
// Port-level checks on the pair agreement index result channel, bound
// to the top level. Uses pai_pkg for field widths.
module pai_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [pai_pkg::PairW-1:0]  agree_count_i,
  input logic [pai_pkg::PairW-1:0]  pair_count_i,
  input logic [pai_pkg::IndexW-1:0] index_q16_i,
  input logic                       valid_res_i,
  input logic                       overflow_i
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(agree_count_i)
      && $stable(pair_count_i) && $stable(index_q16_i) && $stable(overflow_i))
    else $error("result changed while stalled");

  // Agreeing pairs never exceed all pairs
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> agree_count_i <= pair_count_i)
    else $error("agree count above pair count");

  // Fewer than two elements: no pairs, zero ratio
  a_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !valid_res_i |-> pair_count_i == '0 && agree_count_i == '0
      && index_q16_i == '0)
    else $error("invalid result carries nonzero fields");

  // Full agreement gives ratio one
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && valid_res_i && agree_count_i == pair_count_i
      |-> index_q16_i == pai_pkg::IndexW'(65536))
    else $error("full agreement not ratio one");

  // Valid result has pairs and ratio within Q1.16 one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && valid_res_i |-> pair_count_i != '0
      && index_q16_i <= pai_pkg::IndexW'(65536))
    else $error("valid result out of range");

endmodule

bind pair_agreement_index pai_checker u_pai_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .agree_count_i (out_o.agree_count),
  .pair_count_i  (out_o.pair_count),
  .index_q16_i   (out_o.index_q16),
  .valid_res_i   (out_o.valid_res),
  .overflow_i    (out_o.overflow)
);

@@ dv/pair_agreement_index_tb.sv @@
`timescale 1ns / 100ps
// Testbench for pair_agreement_index: streams labeled elements, predicts each set's
// Rand index result and compares it field by field. Depends on pai_pkg and pai_if.
module pair_agreement_index_tb;

  localparam int          CycleLimit  = 4_000_000;
  localparam int          RandomItems = 580;
  localparam int          ReportCap   = 40;
  localparam logic [15:0] LabelMask   = 16'((64'd1 << pai_pkg::LabelBits) - 1);

  // One result as the block should deliver it
  typedef struct packed {
    logic [pai_pkg::PairW-1:0]  agree_count;
    logic [pai_pkg::PairW-1:0]  pair_count;
    logic [pai_pkg::IndexW-1:0] index_q16;
    logic                       valid_res;
    logic                       overflow;
  } index_result_t;

  logic clk;
  logic rst_n;

  pai_in_if  in_if ();
  pai_out_if out_if ();

  pair_agreement_index u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // Predictor state for the set being collected
  logic [15:0]   set_labels_a[$];
  logic [15:0]   set_labels_b[$];
  int unsigned   set_agree_total;
  bit            set_dropped;
  index_result_t expected_indexes[$];

  int  mismatch_count;
  int  cycle_count;
  int  items_sent;
  bit  tx_steady;
  int  rx_hold_req;
  int  rx_stall_left;
  int  rx_stretch_left;
  bit  rx_steady;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("pair_agreement_index_tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < ReportCap) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Fold one accepted element into the set; on the last one queue the result
  task automatic account_element(input logic [15:0] a, input logic [15:0] b,
                                 input logic is_last);
    longint unsigned n;
    longint unsigned pairs;
    longint unsigned ratio;
    longint unsigned total;
    logic [15:0]     ma;
    logic [15:0]     mb;
    index_result_t   r;
    ma = a & LabelMask;
    mb = b & LabelMask;
    if (set_labels_a.size() < pai_pkg::MaxItems) begin
      foreach (set_labels_a[k])
        if ((set_labels_a[k] == ma) == (set_labels_b[k] == mb)) set_agree_total++;
      set_labels_a.push_back(ma);
      set_labels_b.push_back(mb);
    end else begin
      set_dropped = 1'b1;
    end
    if (is_last) begin
      n     = set_labels_a.size();
      total = set_agree_total;
      pairs = (n >= 2) ? (n * (n - 1)) / 2 : 0;
      ratio = (n >= 2) ? (total << 16) / pairs : 0;
      r.agree_count = total[pai_pkg::PairW-1:0];
      r.pair_count  = pairs[pai_pkg::PairW-1:0];
      r.index_q16   = ratio[pai_pkg::IndexW-1:0];
      r.valid_res   = (n >= 2);
      r.overflow    = set_dropped;
      expected_indexes.push_back(r);
      set_labels_a.delete();
      set_labels_b.delete();
      set_agree_total = 0;
      set_dropped     = 1'b0;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    index_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_indexes.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, agree=%0d pairs=%0d",
                                  out_if.agree_count, out_if.pair_count));
      end else begin
        want = expected_indexes.pop_front();
        if (out_if.agree_count !== want.agree_count)
          report_mismatch($sformatf("agree_count %0d, want %0d",
                                    out_if.agree_count, want.agree_count));
        if (out_if.pair_count !== want.pair_count)
          report_mismatch($sformatf("pair_count %0d, want %0d",
                                    out_if.pair_count, want.pair_count));
        if (out_if.index_q16 !== want.index_q16)
          report_mismatch($sformatf("index_q16 %0d, want %0d",
                                    out_if.index_q16, want.index_q16));
        if (out_if.valid_res !== want.valid_res)
          report_mismatch($sformatf("valid_res %0b, want %0b",
                                    out_if.valid_res, want.valid_res));
        if (out_if.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %0b, want %0b",
                                    out_if.overflow, want.overflow));
      end
    end
  end

  // Result-side ready: random stalls, steady stretches, and long hold-offs on request
  always @(posedge clk) begin : result_ready_drive
    int r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold_req != 0) begin
      rx_stall_left = rx_hold_req - 1;
      rx_hold_req   = 0;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_stretch_left == 0) begin
        rx_stretch_left = $urandom_range(100, 1500);
        rx_steady       = ($urandom_range(0, 3) == 0);
      end else begin
        rx_stretch_left--;
      end
      if (rx_stall_left != 0) begin
        rx_stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_steady) begin
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          out_if.ready <= 1'b1;
        end else if (r < 96) begin
          rx_stall_left = $urandom_range(0, 3);
          out_if.ready <= 1'b0;
        end else begin
          rx_stall_left = $urandom_range(20, 80);
          out_if.ready <= 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one element and wait for it to be taken
  task automatic send_element(input logic [15:0] a, input logic [15:0] b,
                              input logic is_last);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.label_a   <= a;
    in_if.label_b   <= b;
    in_if.last_item <= is_last;
    do @(posedge clk); while (!in_if.ready);
    account_element(a, b, is_last);
  endtask

  // Stop offering until every queued result is back
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_indexes.size() != 0) @(posedge clk);
  endtask

  // Mostly labels from a small pool, so that equal labels are common
  function automatic logic [15:0] pick_label(input logic [15:0] base, input int pool);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return base + 16'($urandom_range(0, pool - 1));
    if (r < 90) return 16'($urandom_range(0, 65535));
    if (r < 95) return 16'h0000;
    return 16'hFFFF;
  endfunction

  // Single elements, two-element sets at the label extremes, a truncated ratio, one-hot labels
  task automatic test_directed_sets();
    send_element(16'h0000, 16'hFFFF, 1'b1);
    send_element(16'hFFFF, 16'h0000, 1'b1);
    send_element(16'h0000, 16'h0000, 1'b0);
    send_element(16'hFFFF, 16'hFFFF, 1'b1);
    send_element(16'h0000, 16'h0000, 1'b0);
    send_element(16'h0000, 16'hFFFF, 1'b1);
    send_element(16'hFFFF, 16'hFFFF, 1'b0);
    send_element(16'hFFFF, 16'hFFFF, 1'b1);
    send_element(16'h0007, 16'h0003, 1'b0);
    send_element(16'h0007, 16'h0004, 1'b0);
    send_element(16'h0008, 16'h0004, 1'b1);
    // one-hot labels, all pairs differ in both labelings
    for (int i = 0; i < 8; i++)
      send_element(16'(1) << i, 16'(1) << (15 - i), i == 7);
    wait_results_drained();
  endtask

  // Result side held off: one result parks, the next set backs up the input
  task automatic test_result_backpressure();
    tx_steady   = 1'b1;
    rx_hold_req = 700;
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < 3; i++)
        send_element(pick_label(16'h0010, 2), pick_label(16'h0020, 2), i == 2);
    tx_steady = 1'b0;
    wait_results_drained();
  endtask

  // Fill the store, then drop two more elements, the last one among them
  task automatic test_store_full();
    logic [15:0] base_a;
    logic [15:0] base_b;
    base_a = 16'($urandom_range(0, 65535));
    base_b = 16'($urandom_range(0, 65535));
    for (int i = 0; i < pai_pkg::MaxItems + 2; i++)
      send_element(pick_label(base_a, 4), pick_label(base_b, 3),
                   i == pai_pkg::MaxItems + 1);
    wait_results_drained();
    // next set must start from cleared counters
    send_element(16'h1234, 16'h1234, 1'b0);
    send_element(16'h1234, 16'h4321, 1'b1);
    wait_results_drained();
  endtask

  // Random sets, mostly small, with random pools and idle patterns
  task automatic test_random_sets();
    int          set_size;
    int          r;
    int          pool_a;
    int          pool_b;
    logic [15:0] base_a;
    logic [15:0] base_b;
    while (items_sent < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 85)      set_size = $urandom_range(1, 12);
      else if (r < 97) set_size = $urandom_range(13, 60);
      else             set_size = $urandom_range(61, 200);
      pool_a    = $urandom_range(1, 6);
      pool_b    = $urandom_range(1, 6);
      base_a    = 16'($urandom_range(0, 65535));
      base_b    = 16'($urandom_range(0, 65535));
      tx_steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < set_size; i++) begin
        send_element(pick_label(base_a, pool_a), pick_label(base_b, pool_b),
                     i == set_size - 1);
        items_sent++;
      end
      if ($urandom_range(0, 9) == 0) wait_results_drained();
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.label_a   = '0;
    in_if.label_b   = '0;
    in_if.last_item = 1'b0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    items_sent      = 0;
    tx_steady       = 1'b0;
    rx_hold_req     = 0;
    rx_stall_left   = 0;
    rx_stretch_left = 0;
    rx_steady       = 1'b0;
    set_agree_total = 0;
    set_dropped     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_sets();
    test_result_backpressure();
    test_random_sets();
    test_store_full();

    wait_results_drained();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pair_agreement_index_tb OK");
    end else begin
      $display("pair_agreement_index_tb NOT OK");
    end
    $finish;
  end

endmodule
